// File: rtl/core/windowed_limited_integrator_macros.svh
// Assertion macros for the windowed limited integrator.
`ifndef WINDOWED_LIMITED_INTEGRATOR_MACROS_SVH
`define WINDOWED_LIMITED_INTEGRATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WLI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define WLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define WLI_ASSERT(lbl, cond, msg)
`define WLI_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/wli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wli_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int SAMPLE_WIDTH = 32;
  localparam int TIME_WIDTH   = 32;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 64;
  localparam int DVD_W  = SUM_W + 1;
  localparam int SPAN_W = 33;
  localparam int ENT_W  = SAMPLE_WIDTH + TIME_WIDTH;
  localparam int ADDR_W = 5;

  localparam logic [1:0] LIM_SAT  = 2'd1;
  localparam logic [1:0] LIM_WRAP = 2'd2;
  localparam logic [1:0] WIN_TICK = 2'd1;
  localparam logic [1:0] WIN_SMPL = 2'd2;

  localparam logic [2:0] REG_LIMIT_MODE  = 3'd0;
  localparam logic [2:0] REG_UPPER       = 3'd1;
  localparam logic [2:0] REG_LOWER       = 3'd2;
  localparam logic [2:0] REG_INIT        = 3'd3;
  localparam logic [2:0] REG_WINDOW_MODE = 3'd4;
  localparam logic [2:0] REG_WIN_SAMPLES = 3'd5;
  localparam logic [2:0] REG_WIN_TICKS   = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           restart;
    logic [TIME_WIDTH-1:0]          timestamp;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               window_overflow;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_PUSH,
    ST_LIM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/wli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/wli_rem.sv
`timescale 1ns / 1ps
`default_nettype none
module wli_rem
  import wli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [SPAN_W-1:0]      remainder
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SPAN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DVD_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = SPAN_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[SPAN_W-1:0];
      end
      q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// File: rtl/core/windowed_limited_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// Windowed limited integrator. One request in, one result out. The 64-bit sum
// and the window bookkeeping live in registers; the window samples and their
// timestamps share one 256-entry RAM with a registered read. An accepted item
// goes through a limit step and an output step. With a window it first pushes
// its sample into the store; after a push that is not a first sample or
// restart, the oldest entries are read and evicted one by one while they have
// expired, and a full store drops its oldest entry before the push. Wrap mode
// adds a bit-serial remainder of the 65-bit difference from the lower bound.
// Inputs are taken only while no item is in flight. A finished result may
// wait in the output register; the next item stalls in its output state
// until that register is free.
`include "windowed_limited_integrator_macros.svh"
module windowed_limited_integrator
  import wli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_rsp_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  // configuration
  logic [1:0]         limit_mode_r;
  logic signed [31:0] upper_r, lower_r, init_r;
  logic [1:0]         window_mode_r;
  logic [8:0]         win_samples_r;
  logic [31:0]        win_ticks_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r  <= '0;
      upper_r       <= '0;
      lower_r       <= '0;
      init_r        <= '0;
      window_mode_r <= '0;
      win_samples_r <= 9'd100;
      win_ticks_r   <= 32'd100;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LIMIT_MODE:  limit_mode_r  <= pwdata[1:0];
        REG_UPPER:       upper_r       <= pwdata;
        REG_LOWER:       lower_r       <= pwdata;
        REG_INIT:        init_r        <= pwdata;
        REG_WINDOW_MODE: window_mode_r <= pwdata[1:0];
        REG_WIN_SAMPLES: win_samples_r <= pwdata[8:0];
        REG_WIN_TICKS:   win_ticks_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIMIT_MODE:  prdata = {30'd0, limit_mode_r};
      REG_UPPER:       prdata = upper_r;
      REG_LOWER:       prdata = lower_r;
      REG_INIT:        prdata = init_r;
      REG_WINDOW_MODE: prdata = {30'd0, window_mode_r};
      REG_WIN_SAMPLES: prdata = {23'd0, win_samples_r};
      REG_WIN_TICKS:   prdata = win_ticks_r;
      default:         prdata = '0;
    endcase
  end

  // datapath state
  state_t                  state_r, state_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    started_r, started_nxt;
  logic [IDX_W-1:0]        oldest_r, oldest_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic [TIME_WIDTH-1:0]   t_r, t_nxt;
  logic                    flag_r, flag_nxt;
  logic                    pre_r, pre_nxt;
  logic                    first_r, first_nxt;
  logic                    neg_r, neg_nxt;
  logic                    ovalid_r, ovalid_nxt;
  out_rsp_t                odata_r, odata_nxt;

  logic                    windowed, tick_mode;
  logic [SUM_W-1:0]        x64, init64, lo64, v64;
  logic signed [31:0]      hi, lo;
  logic [SPAN_W-1:0]       span, rem_fix;
  logic signed [DVD_W-1:0] diff;
  logic [DVD_W-1:0]        diff_mag;
  logic [CNT_W-1:0]        n_eff;
  logic [IDX_W:0]          slot_sum, old_inc;
  logic [IDX_W-1:0]        push_slot, oldest_next;
  logic [TIME_WIDTH-1:0]   ft, age;
  logic [SAMPLE_WIDTH-1:0] fv;
  logic                    drop;
  logic                    ram_we;
  logic [ENT_W-1:0]        ram_rdata;
  logic                    rem_start, rem_busy, rem_done;
  logic [SPAN_W-1:0]       rem_val;

  assign windowed  = (window_mode_r == WIN_TICK) || (window_mode_r == WIN_SMPL);
  assign tick_mode = (window_mode_r == WIN_TICK);
  assign x64       = SUM_W'(signed'(in_data.sample));
  assign init64    = SUM_W'(init_r);
  assign hi        = (upper_r > lower_r) ? upper_r : lower_r;
  assign lo        = (upper_r > lower_r) ? lower_r : upper_r;
  assign lo64      = SUM_W'(lo);
  assign span      = SPAN_W'({hi[31], hi} - {lo[31], lo} + 33'd1);
  assign diff      = $signed({sum_r[SUM_W-1], sum_r}) - DVD_W'(lo);
  assign diff_mag  = diff[DVD_W-1] ? DVD_W'(-diff) : DVD_W'(diff);
  assign n_eff     = (32'(win_samples_r) > 32'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                              : CNT_W'(win_samples_r);
  assign slot_sum  = (IDX_W + 1)'(oldest_r) + (IDX_W + 1)'(kept_r);
  assign push_slot = (slot_sum >= (IDX_W + 1)'(WINDOW_DEPTH))
                     ? IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW_DEPTH)) : IDX_W'(slot_sum);
  assign old_inc   = (IDX_W + 1)'(oldest_r) + 1'b1;
  assign oldest_next = (old_inc >= (IDX_W + 1)'(WINDOW_DEPTH)) ? '0 : IDX_W'(old_inc);
  assign fv        = ram_rdata[ENT_W-1:TIME_WIDTH];
  assign ft        = ram_rdata[TIME_WIDTH-1:0];
  assign v64       = SUM_W'(signed'(fv));
  assign age       = (t_r >= ft) ? t_r - ft : '0;
  assign drop      = pre_r || !tick_mode || (64'(age) > 64'(win_ticks_r));
  assign rem_fix   = (neg_r && rem_val != '0) ? span - rem_val : rem_val;

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    started_nxt = started_r;
    oldest_nxt  = oldest_r;
    kept_nxt    = kept_r;
    x_nxt       = x_r;
    t_nxt       = t_r;
    flag_nxt    = flag_r;
    pre_nxt     = pre_r;
    first_nxt   = first_r;
    neg_nxt     = neg_r;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;
    ram_we      = 1'b0;
    rem_start   = 1'b0;
    in_ready    = (state_r == ST_IDLE);
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt       = in_data.sample;
          t_nxt       = in_data.timestamp;
          flag_nxt    = 1'b0;
          pre_nxt     = 1'b0;
          started_nxt = 1'b1;
          first_nxt   = !started_r || in_data.restart;
          state_nxt   = ST_LIM;
          if (!started_r || in_data.restart) begin
            sum_nxt = in_data.restart ? x64 : init64 + x64;
            if (windowed) begin
              kept_nxt   = '0;
              oldest_nxt = '0;
              state_nxt  = ST_PUSH;
            end
          end else begin
            sum_nxt = sum_r + x64;
            if (windowed) begin
              if (kept_r == CNT_W'(WINDOW_DEPTH)) begin
                pre_nxt   = 1'b1;
                flag_nxt  = tick_mode;
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_PUSH;
              end
            end
          end
        end
      end
      ST_RD: begin
        if (pre_r || (tick_mode ? (kept_r != '0) : (kept_r > n_eff))) begin
          state_nxt = ST_EV;
        end else begin
          state_nxt = ST_LIM;
        end
      end
      ST_EV: begin
        if (drop) begin
          sum_nxt    = sum_r - v64;
          oldest_nxt = oldest_next;
          kept_nxt   = kept_r - 1'b1;
        end
        if (pre_r) begin
          pre_nxt   = 1'b0;
          state_nxt = ST_PUSH;
        end else if (drop) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_LIM;
        end
      end
      ST_PUSH: begin
        ram_we    = 1'b1;
        kept_nxt  = kept_r + 1'b1;
        state_nxt = first_r ? ST_LIM : ST_RD;
      end
      ST_LIM: begin
        state_nxt = ST_OUT;
        if (limit_mode_r == LIM_SAT) begin
          if ($signed(sum_r) > $signed(SUM_W'(hi))) begin
            sum_nxt = SUM_W'(hi);
          end else if ($signed(sum_r) < $signed(lo64)) begin
            sum_nxt = lo64;
          end
        end else if (limit_mode_r == LIM_WRAP) begin
          rem_start = 1'b1;
          neg_nxt   = diff[DVD_W-1];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          sum_nxt   = lo64 + SUM_W'(rem_fix);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt                = 1'b1;
          odata_nxt.result          = sum_r[31:0];
          odata_nxt.window_overflow = flag_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sum_r     <= '0;
      started_r <= 1'b0;
      oldest_r  <= '0;
      kept_r    <= '0;
      ovalid_r  <= 1'b0;
      pre_r     <= 1'b0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_r     <= sum_nxt;
      started_r <= started_nxt;
      oldest_r  <= oldest_nxt;
      kept_r    <= kept_nxt;
      ovalid_r  <= ovalid_nxt;
      pre_r     <= pre_nxt;
      first_r   <= first_nxt;
    end
    x_r     <= x_nxt;
    t_r     <= t_nxt;
    flag_r  <= flag_nxt;
    neg_r   <= neg_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  wli_ram #(
    .WIDTH(ENT_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(push_slot),
    .wdata({x_r, t_r}),
    .raddr(oldest_r),
    .rdata(ram_rdata)
  );

  wli_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (diff_mag),
    .divisor  (span),
    .busy     (rem_busy),
    .done     (rem_done),
    .remainder(rem_val)
  );

  `WLI_ASSERT(a_kept_bound, kept_r <= CNT_W'(WINDOW_DEPTH), "kept count above store depth")
  `WLI_ASSERT(a_oldest_bound, 32'(oldest_r) < 32'(WINDOW_DEPTH), "oldest slot out of range")
  `WLI_ASSERT_IMP(a_rem_idle, state_r == ST_IDLE, !rem_busy, "remainder busy while idle")
  `WLI_ASSERT_IMP(a_push_room, ram_we, kept_r < CNT_W'(WINDOW_DEPTH), "push into full store")
endmodule
`default_nettype wire
